// ----- design/uir_pkg.sv -----
// Shared types and constants for the uptime interval reporter.
// Used by uir_div and uptime_interval_reporter_unit; no dependencies.
package uir_pkg;

	// Configuration register indexes
	localparam logic REG_INTERVAL_SECONDS = 1'b0;
	localparam logic REG_TICKS_PER_SECOND = 1'b1;

	// Request kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_POLL  = 1'b1;

	localparam logic [31:0] TPS_RESET = 32'd100000000;

	// Divider iteration count
	localparam int unsigned DIV_ITERS_W = 7;
	localparam logic [DIV_ITERS_W-1:0] DIV_TICK_ITERS = 7'd64;

	// Time split constants
	localparam logic [31:0] SECS_PER_MIN  = 32'd60;
	localparam logic [31:0] MINS_PER_HOUR = 32'd60;
	localparam logic [31:0] HOURS_PER_DAY = 32'd24;

	// Fixed reciprocals, exact for any 32-bit value: ceil(2^37 / 60) and ceil(2^36 / 24)
	localparam logic [31:0] RECIP_60       = 32'h8888_8889;
	localparam int unsigned RECIP_60_SHIFT = 37;
	localparam logic [31:0] RECIP_24       = 32'hAAAA_AAAB;
	localparam int unsigned RECIP_24_SHIFT = 36;

	// Sequencer states, one-hot
	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_DECODE = 12'b000000000010,
		ST_SAT    = 12'b000000000100,
		ST_ACC    = 12'b000000001000,
		ST_DTICK  = 12'b000000010000,
		ST_MSEC   = 12'b000000100000,
		ST_RSEC   = 12'b000001000000,
		ST_MMIN   = 12'b000010000000,
		ST_RMIN   = 12'b000100000000,
		ST_MHR    = 12'b001000000000,
		ST_RHR    = 12'b010000000000,
		ST_PUT    = 12'b100000000000
	} state_t;

	// Divider control from the sequencer
	typedef struct packed {
		logic                   start;
		logic [DIV_ITERS_W-1:0] iters;
	} div_ctl_t;

endpackage

// ----- design/uir_div.sv -----
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on uir_pkg for div_ctl_t and the iteration count width.
module uir_div import uir_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_ctl_t    ctl,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quotient
);

	logic                   busy_q;
	logic                   done_q;
	logic [DIV_ITERS_W-1:0] cnt_q;
	logic [63:0]            dvd_q;
	logic [31:0]            rem_q;
	logic [31:0]            dsr_q;

	logic [32:0] rem_sh;
	logic [33:0] sub;
	logic        ge;

	// Shift one dividend bit into the partial remainder and trial-subtract
	assign rem_sh = {rem_q, dvd_q[63]};
	assign sub    = {1'b0, rem_sh} - {2'b00, dsr_q};
	assign ge     = ~sub[33];

	// Control: count iterations, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_ITERS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then advance one bit per cycle
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], ge};
			rem_q <= ge ? sub[31:0] : rem_sh[31:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ----- design/uptime_interval_reporter_unit.sv -----
// Uptime interval reporter. One request in, one result out. A start request goes through
// decode and saturation before the result register; a poll that does not report goes from
// decode straight to it; a poll that reports first runs the restoring divider (skipped when
// the tick rate is zero), which retires one quotient bit per cycle for the tick-to-second division;
// the splits by 60, 60 and 24 then each take a multiply by a fixed reciprocal on the
// shared multiplier and a remainder step. Input is stalled while a request is being worked
// on, so the next request is taken in the cycle after the result register loads at the earliest;
// a stalled result register holds the sequencer in its last state until it frees up.
// Depends on uir_pkg and uir_div.
module uptime_interval_reporter_unit import uir_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// Request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] tick_sample,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        report_valid,
	output logic [15:0] days,
	output logic [4:0]  hours,
	output logic [5:0]  minutes,
	output logic [5:0]  seconds
);

	state_t state_q;

	logic [31:0] interval_seconds_q;
	logic [31:0] ticks_per_second_q;

	logic [63:0] uptime_q;
	logic [31:0] last_tick_q;
	logic [31:0] interval_q;
	logic        running_q;

	logic        kind_q;
	logic [31:0] sample_q;
	logic [31:0] diff_q;
	logic [63:0] product_q;
	logic [31:0] split_q;

	logic        res_valid_q;
	logic [15:0] res_days_q;
	logic [4:0]  res_hours_q;
	logic [5:0]  res_minutes_q;
	logic [5:0]  res_seconds_q;

	logic        out_valid_q;
	logic        out_report_q;
	logic [15:0] out_days_q;
	logic [4:0]  out_hours_q;
	logic [5:0]  out_minutes_q;
	logic [5:0]  out_seconds_q;

	logic [31:0] diff;
	logic        report_hit;
	logic [63:0] uptime_sum;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_full;
	logic [31:0] quot60;
	logic [31:0] rem60;
	logic [31:0] quot24;
	logic [31:0] rem24;
	logic        out_free;

	div_ctl_t    div_ctl;
	logic [63:0] div_dividend;
	logic [31:0] div_divisor;
	logic        div_done;
	logic [63:0] div_quot;

	// Configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_seconds_q <= '0;
			ticks_per_second_q <= TPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_INTERVAL_SECONDS: interval_seconds_q <= cfg_data;
				REG_TICKS_PER_SECOND: ticks_per_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Poll decision
	assign diff       = sample_q - last_tick_q;
	assign report_hit = running_q && (interval_q != '0) && (diff >= interval_q);
	assign uptime_sum = uptime_q + {32'b0, diff_q};
	assign out_free   = !out_valid_q || !out_stall;

	assign in_stall = (state_q != ST_IDLE);

	// Shared multiplier: start-time product, then reciprocals for the time split
	always_comb begin
		mul_a = interval_seconds_q;
		mul_b = ticks_per_second_q;
		unique case (state_q)
			ST_MSEC, ST_MMIN: begin
				mul_a = split_q;
				mul_b = RECIP_60;
			end
			ST_MHR: begin
				mul_a = split_q;
				mul_b = RECIP_24;
			end
			default: ;
		endcase
	end

	assign mul_full = {32'b0, mul_a} * {32'b0, mul_b};

	// Quotient and remainder from the registered reciprocal product
	// (seconds per minute and minutes per hour share the same divisor)
	assign quot60 = 32'(product_q[63:RECIP_60_SHIFT]);
	assign rem60  = split_q - quot60 * SECS_PER_MIN;
	assign quot24 = 32'(product_q[63:RECIP_24_SHIFT]);
	assign rem24  = split_q - quot24 * HOURS_PER_DAY;

	// Divider request: uptime ticks by the tick rate
	always_comb begin
		div_ctl.start = (state_q == ST_ACC) && (ticks_per_second_q != '0);
		div_ctl.iters = DIV_TICK_ITERS;
	end

	assign div_dividend = uptime_sum;
	assign div_divisor  = ticks_per_second_q;

	uir_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot)
	);

	// Sequencer and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			uptime_q    <= '0;
			last_tick_q <= '0;
			interval_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (kind_q == KIND_START) begin
						last_tick_q <= sample_q;
						uptime_q    <= '0;
						running_q   <= 1'b1;
						state_q     <= ST_SAT;
					end else if (report_hit) begin
						state_q <= ST_ACC;
					end else begin
						state_q <= ST_PUT;
					end
				end
				ST_SAT: begin
					interval_q <= (product_q[63:32] != '0) ? 32'hFFFF_FFFF : product_q[31:0];
					state_q    <= ST_PUT;
				end
				ST_ACC: begin
					uptime_q    <= uptime_sum;
					last_tick_q <= sample_q;
					state_q     <= (ticks_per_second_q != '0) ? ST_DTICK : ST_MSEC;
				end
				ST_DTICK: if (div_done) state_q <= ST_MSEC;
				ST_MSEC:  state_q <= ST_RSEC;
				ST_RSEC:  state_q <= ST_MMIN;
				ST_MMIN:  state_q <= ST_RMIN;
				ST_RMIN:  state_q <= ST_MHR;
				ST_MHR:   state_q <= ST_RHR;
				ST_RHR:   state_q <= ST_PUT;
				ST_PUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request capture and working result registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_q   <= kind;
			sample_q <= tick_sample;
		end
		if (state_q == ST_DECODE || state_q == ST_MSEC || state_q == ST_MMIN
				|| state_q == ST_MHR) begin
			product_q <= mul_full;
		end
		if (state_q == ST_DECODE) begin
			diff_q        <= diff;
			res_valid_q   <= 1'b0;
			res_days_q    <= '0;
			res_hours_q   <= '0;
			res_minutes_q <= '0;
			res_seconds_q <= '0;
		end
		// A zero tick rate reads as all-ones seconds
		if (state_q == ST_ACC) begin
			split_q <= '1;
		end
		if (state_q == ST_DTICK && div_done) begin
			split_q <= div_quot[31:0];
		end
		if (state_q == ST_RSEC) begin
			res_seconds_q <= rem60[5:0];
			split_q       <= quot60;
		end
		if (state_q == ST_RMIN) begin
			res_minutes_q <= rem60[5:0];
			split_q       <= quot60;
		end
		if (state_q == ST_RHR) begin
			res_hours_q <= rem24[4:0];
			res_days_q  <= quot24[15:0];
			res_valid_q <= 1'b1;
		end
	end

	// Output register: hold while stalled, load when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUT && out_free) begin
			out_report_q  <= res_valid_q;
			out_days_q    <= res_days_q;
			out_hours_q   <= res_hours_q;
			out_minutes_q <= res_minutes_q;
			out_seconds_q <= res_seconds_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign report_valid = out_report_q;
	assign days         = out_days_q;
	assign hours        = out_hours_q;
	assign minutes      = out_minutes_q;
	assign seconds      = out_seconds_q;

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for uptime_interval_reporter_unit: directed and random requests,
// predicted uptime reports, random idling on both channels and one long result hold-off.
// Depends on uir_pkg and the RTL of uptime_interval_reporter_unit.
module tb_top import uir_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS       = 1600;
	localparam int RESULT_HOLD_CYCLES = 300;
	localparam int IDLE_SETTLE        = 8;
	localparam int END_SETTLE         = 200;
	localparam int WATCHDOG_LIMIT     = 4000;

	typedef struct packed {
		logic        report_valid;
		logic [15:0] days;
		logic [4:0]  hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
	} uptime_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = REG_INTERVAL_SECONDS;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = KIND_START;
	logic [31:0] tick_sample = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        report_valid;
	logic [15:0] days;
	logic [4:0]  hours;
	logic [5:0]  minutes;
	logic [5:0]  seconds;

	// Predictor copy of the registers and the tracking state
	logic [31:0] cfg_interval_s = '0;
	logic [31:0] cfg_tick_rate = TPS_RESET;
	logic [63:0] up_ticks = '0;
	logic [31:0] last_sample = '0;
	logic [31:0] interval_len = '0;
	logic        tracking = 1'b0;

	uptime_report_t pending_reports[$];

	logic no_idle = 1'b0;
	logic results_hold_req = 1'b0;
	int   mismatches = 0;
	int   requests_sent = 0;
	int   results_checked = 0;
	int   reports_seen = 0;
	int   reg_writes = 0;
	int   idle_cycles = 0;

	uptime_interval_reporter_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.tick_sample(tick_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.report_valid(report_valid),
		.days(days),
		.hours(hours),
		.minutes(minutes),
		.seconds(seconds)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Advance the tracking state by one request and return the report it should produce
	function automatic uptime_report_t predict_report(logic req_kind, logic [31:0] sample);
		uptime_report_t rep;
		logic [63:0] product;
		logic [31:0] span_ticks;
		logic [31:0] whole;
		rep = '0;
		if (req_kind == KIND_START) begin
			product = 64'(cfg_interval_s) * 64'(cfg_tick_rate);
			interval_len = (product > 64'hFFFF_FFFF) ? '1 : product[31:0];
			last_sample = sample;
			up_ticks = '0;
			tracking = 1'b1;
			return rep;
		end
		if (!tracking || interval_len == 0)
			return rep;
		span_ticks = sample - last_sample;
		if (span_ticks < interval_len)
			return rep;
		up_ticks += 64'(span_ticks);
		last_sample = sample;
		// A zero rate after start reads as the largest second count
		whole = (cfg_tick_rate == 0) ? '1 : 32'(up_ticks / 64'(cfg_tick_rate));
		rep.report_valid = 1'b1;
		rep.seconds = 6'(whole % SECS_PER_MIN);
		whole = whole / SECS_PER_MIN;
		rep.minutes = 6'(whole % MINS_PER_HOUR);
		whole = whole / MINS_PER_HOUR;
		rep.hours = 5'(whole % HOURS_PER_DAY);
		rep.days = 16'(whole / HOURS_PER_DAY);
		return rep;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] pick_interval_s();
		case ($urandom_range(0, 5))
			0: return 32'd1;
			1: return $urandom_range(1, 20);
			2: return $urandom_range(1, 100000);
			3: return 32'hFFFF_FFFF;
			4: return $urandom | 32'd1;
			default: return $urandom_range(1, 3600);
		endcase
	endfunction

	function automatic logic [31:0] pick_tick_rate();
		case ($urandom_range(0, 5))
			0: return 32'd1;
			1: return $urandom_range(1, 1000);
			2: return TPS_RESET;
			3: return 32'hFFFF_FFFF;
			4: return $urandom | 32'd1;
			default: return $urandom_range(1, 100);
		endcase
	endfunction

	// Offer one request, hold it until taken, then leave a random gap
	task automatic send_request(logic req_kind, logic [31:0] sample);
		int gap;
		in_valid <= 1'b1;
		kind <= req_kind;
		tick_sample <= sample;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_reports.push_back(predict_report(req_kind, sample));
		requests_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop the request line and wait until every expected result has come back
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	// Write both registers back to back while the block is idle
	task automatic program_regs(logic [31:0] interval_s, logic [31:0] tick_rate);
		wait_for_idle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_INTERVAL_SECONDS;
		cfg_data <= interval_s;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_interval_s = interval_s;
		cfg_index <= REG_TICKS_PER_SECOND;
		cfg_data <= tick_rate;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_tick_rate = tick_rate;
		cfg_valid <= 1'b0;
		reg_writes += 2;
	endtask

	task automatic test_poll_before_start();
		send_request(KIND_POLL, 32'h0000_0000);
		send_request(KIND_POLL, 32'hFFFF_FFFF);
	endtask

	task automatic test_zero_interval();
		// Reset interval of zero seconds, then a zero tick rate at start
		send_request(KIND_START, 32'h1234_5678);
		send_request(KIND_POLL, 32'h9234_5678);
		program_regs(32'd5, 32'd0);
		send_request(KIND_START, 32'h0000_0000);
		send_request(KIND_POLL, 32'hFFFF_FFFF);
	endtask

	task automatic test_interval_boundaries();
		program_regs(32'd2, 32'd10);
		send_request(KIND_START, 32'd0);
		send_request(KIND_POLL, 32'd19);
		send_request(KIND_POLL, 32'd20);
		send_request(KIND_POLL, 32'd25);
		send_request(KIND_POLL, 32'hFFFF_FFFF);
		// Distance across the counter wrap
		send_request(KIND_POLL, 32'd30);
	endtask

	task automatic test_saturation_and_truncation();
		program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(KIND_START, 32'hFFFF_FFFF);
		send_request(KIND_POLL, 32'hFFFF_FFFE);
		// Uptime past 2^32 seconds at one tick per second
		program_regs(32'd1, 32'd1);
		send_request(KIND_START, 32'd0);
		send_request(KIND_POLL, 32'hFFFF_FFFF);
		send_request(KIND_POLL, 32'hFFFF_FFFE);
		send_request(KIND_POLL, 32'hFFFF_FFFD);
	endtask

	task automatic test_zero_rate_after_start();
		program_regs(32'd3, 32'd1);
		send_request(KIND_START, 32'd100);
		send_request(KIND_POLL, 32'd103);
		program_regs(32'd3, 32'd0);
		send_request(KIND_POLL, 32'd200);
	endtask

	task automatic test_result_backpressure();
		program_regs(32'd1, 32'd4);
		no_idle = 1'b1;
		send_request(KIND_START, $urandom);
		results_hold_req <= 1'b1;
		repeat (12) send_request(KIND_POLL, last_sample + interval_len);
		no_idle = 1'b0;
		wait_for_idle();
	endtask

	task automatic test_random_traffic();
		int counted;
		int r;
		int phase_len;
		logic [32:0] wide;
		logic [31:0] delta;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			program_regs(pick_interval_s(), pick_tick_rate());
			no_idle = ($urandom_range(0, 4) == 0);
			send_request(KIND_START, $urandom);
			counted++;
			phase_len = $urandom_range(100, 250);
			if (phase_len > RANDOM_ITEMS - counted)
				phase_len = RANDOM_ITEMS - counted;
			repeat (phase_len) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					// Reach the interval, exactly or a little past it
					wide = 33'(interval_len) + 33'((r < 40) ? 0 : $urandom_range(1, 1000));
					delta = wide[32] ? interval_len : wide[31:0];
					send_request(KIND_POLL, last_sample + delta);
				end else if (r < 75) begin
					delta = $urandom_range(0, interval_len - 1);
					send_request(KIND_POLL, last_sample + delta);
				end else if (r < 80) begin
					send_request(KIND_POLL, last_sample + interval_len - 1);
				end else if (r < 92) begin
					send_request(KIND_POLL, $urandom);
				end else begin
					send_request(KIND_START, $urandom);
				end
				counted++;
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_poll_before_start();
		test_zero_interval();
		test_interval_boundaries();
		test_saturation_and_truncation();
		test_zero_rate_after_start();
		test_result_backpressure();
		test_random_traffic();
		wait_for_idle();
		repeat (END_SETTLE) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$error("%0d expected results never arrived", pending_reports.size());
			mismatches++;
		end
		$display("Run covered %0d requests and %0d results (%0d reports) over %0d register writes.",
			requests_sent, results_checked, reports_seen, reg_writes);
		$display("Directed corners, wrap, saturation, zero rate and one long result hold-off included.");
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Drive the result stall: random runs, plus one long hold when asked
	initial begin
		int run;
		logic stalling;
		run = 0;
		stalling = 1'b0;
		forever begin
			@(posedge clk);
			if (results_hold_req) begin
				out_stall <= 1'b1;
				repeat (RESULT_HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				results_hold_req <= 1'b0;
				stalling = 1'b0;
				run = 0;
			end else if (run > 0) begin
				run--;
			end else if (!stalling && !no_idle) begin
				run = pick_gap();
				if (run > 0) begin
					stalling = 1'b1;
					out_stall <= 1'b1;
					run--;
				end
			end else begin
				stalling = 1'b0;
				out_stall <= 1'b0;
				run = $urandom_range(0, 20);
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin
		uptime_report_t want;
		if (out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$error("result taken with no request outstanding");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("report_valid", 32'(want.report_valid), 32'(report_valid));
				check_field("days", 32'(want.days), 32'(days));
				check_field("hours", 32'(want.hours), 32'(hours));
				check_field("minutes", 32'(want.minutes), 32'(minutes));
				check_field("seconds", 32'(want.seconds), 32'(seconds));
				results_checked++;
				if (want.report_valid)
					reports_seen++;
			end
		end
	end

	// End the run when no channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
